// File: hw/rtl/twtls_pkg.sv
// Shared types and constants for the two-way traffic light sequencer.
package twtls_pkg;

    localparam int unsigned COUNT_W = 18;
    localparam int unsigned SECS_W  = 8;
    localparam int unsigned CFG_IDX_W = 8;

    typedef enum logic [1:0] {
        PH_ALL_RED   = 2'd0,
        PH_YELLOW    = 2'd1,
        PH_GREEN_ONE = 2'd2,
        PH_GREEN_TWO = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GREEN_ONE = 8'd0,
        CFG_GREEN_TWO = 8'd1,
        CFG_YELLOW    = 8'd2,
        CFG_ALL_RED   = 8'd3
    } cfg_idx_t;

    typedef struct packed {
        logic one_green;
        logic one_yellow;
        logic one_red;
        logic two_green;
        logic two_yellow;
        logic two_red;
    } lamps_t;

    localparam logic [SECS_W-1:0] GREEN_ONE_RST = 8'd10;
    localparam logic [SECS_W-1:0] GREEN_TWO_RST = 8'd10;
    localparam logic [SECS_W-1:0] YELLOW_RST    = 8'd3;
    localparam logic [SECS_W-1:0] ALL_RED_RST   = 8'd2;

endpackage

// File: hw/rtl/two_way_traffic_light_sequencer.sv
// Top level of the two-way traffic light sequencer: phase timer, sequencer and beat registers.
// Every input beat (one tick flag) yields one result beat carrying the lamps of the phase in
// force and the phase that follows. A beat is taken every clock cycle unless a full result
// register waits on m_ready; a beat passes the input register, then the result register; the
// combinational path between them is the tick counter increment and its compare against the
// phase duration times TICKS_PER_SECOND. Phase durations are written through the configuration
// channel, which is always ready; writes to indexes beyond the four registers are dropped.
module two_way_traffic_light_sequencer
    import twtls_pkg::*;
#(
    parameter int unsigned TICKS_PER_SECOND = 1000
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_tick,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_lamp_one_green,
    output logic                 m_lamp_one_yellow,
    output logic                 m_lamp_one_red,
    output logic                 m_lamp_two_green,
    output logic                 m_lamp_two_yellow,
    output logic                 m_lamp_two_red,
    output logic [1:0]           m_next_phase,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SECS_W-1:0]    cfg_data
);

    localparam int unsigned LIMIT_W = SECS_W + $clog2(TICKS_PER_SECOND + 1);

    logic [SECS_W-1:0]  green_one_reg, green_two_reg, yellow_reg, all_red_reg;
    phase_t             phase_reg, phase_next;
    logic [1:0]         step_reg, step_next;
    logic [COUNT_W-1:0] count_reg, count_next, count_inc;
    logic               in_valid_reg, in_tick_reg;
    logic               out_valid_reg;
    lamps_t             lamps_reg, lamps_cur;
    phase_t             next_phase_reg;
    logic               advance;
    logic [SECS_W-1:0]  secs;
    logic [LIMIT_W-1:0] limit;
    logic               expired;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            green_one_reg <= GREEN_ONE_RST;
            green_two_reg <= GREEN_TWO_RST;
            yellow_reg    <= YELLOW_RST;
            all_red_reg   <= ALL_RED_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_GREEN_ONE: green_one_reg <= cfg_data;
                CFG_GREEN_TWO: green_two_reg <= cfg_data;
                CFG_YELLOW:    yellow_reg    <= cfg_data;
                CFG_ALL_RED:   all_red_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (phase_reg)
            PH_ALL_RED:   secs = all_red_reg;
            PH_YELLOW:    secs = yellow_reg;
            PH_GREEN_ONE: secs = green_one_reg;
            default:      secs = green_two_reg;
        endcase
        limit     = LIMIT_W'(secs) * LIMIT_W'(TICKS_PER_SECOND);
        count_inc = count_reg + COUNT_W'(1);
        expired   = count_inc >= COUNT_W'(limit);
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        step_next  = step_reg;
        count_next = count_reg;
        if (in_tick_reg) begin
            count_next = count_inc;
            if (expired) begin
                count_next = '0;
                if (phase_reg == PH_YELLOW) begin
                    case (step_reg)
                        2'd0:    phase_next = PH_GREEN_ONE;
                        2'd2:    phase_next = PH_GREEN_TWO;
                        default: phase_next = PH_ALL_RED;
                    endcase
                    step_next = step_reg + 2'd1;
                end else begin
                    phase_next = PH_YELLOW;
                end
            end
        end
    end

    // outputs
    always_comb begin
        lamps_cur            = '0;
        lamps_cur.one_green  = (phase_reg == PH_GREEN_ONE);
        lamps_cur.one_yellow = (phase_reg == PH_YELLOW);
        lamps_cur.one_red    = (phase_reg == PH_ALL_RED) || (phase_reg == PH_GREEN_TWO);
        lamps_cur.two_green  = (phase_reg == PH_GREEN_TWO);
        lamps_cur.two_yellow = 1'b0;
        lamps_cur.two_red    = (phase_reg != PH_GREEN_TWO);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_ALL_RED;
            step_reg      <= 2'd0;
            count_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                step_reg      <= step_next;
                count_reg     <= count_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_tick_reg <= s_tick;
        end
        if (advance) begin
            lamps_reg      <= lamps_cur;
            next_phase_reg <= phase_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_lamp_one_green  = lamps_reg.one_green;
    assign m_lamp_one_yellow = lamps_reg.one_yellow;
    assign m_lamp_one_red    = lamps_reg.one_red;
    assign m_lamp_two_green  = lamps_reg.two_green;
    assign m_lamp_two_yellow = lamps_reg.two_yellow;
    assign m_lamp_two_red    = lamps_reg.two_red;
    assign m_next_phase      = next_phase_reg;

endmodule
